### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/kbp_pkg.sv
// types and constants for the keyed token bucket policer
// no dependencies
`default_nettype none
package kbp_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned TOK_W  = 16;
  localparam int unsigned INTV_W = 32;
  localparam int unsigned TIME_W = 56;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV
  } kbp_state_e;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic rd_en;
    logic div_start;
    logic wr_new;
    logic wr_upd;
    logic finish_early;
  } kbp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic early_done;
    logic entry_valid;
    logic div_done;
  } kbp_sts_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] last_time;
    logic [TOK_W-1:0]  tokens;
  } kbp_entry_t;

endpackage
`default_nettype wire

### hw/rtl/kbp_ctrl.sv
// controller state machine of the policer
// depends on kbp_pkg
`default_nettype none
module kbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire kbp_pkg::kbp_sts_t sts_i,
  output kbp_pkg::kbp_cmd_t      cmd_o,
  output logic                   busy_o
);
  import kbp_pkg::*;

  kbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.early_done ? ST_IDLE : ST_LOAD;
      end
      ST_LOAD: begin
        state_d = sts_i.entry_valid ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start_i;
      end
      ST_CHECK: begin
        cmd_o.finish_early = sts_i.early_done;
        cmd_o.rd_en        = !sts_i.early_done;
      end
      ST_LOAD: begin
        cmd_o.div_start = sts_i.entry_valid;
        cmd_o.wr_new    = !sts_i.entry_valid;
      end
      ST_DIV: begin
        cmd_o.wr_upd = sts_i.div_done;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/kbp_div.sv
// restoring divider, one quotient bit per cycle
// depends on kbp_pkg
`default_nettype none
module kbp_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [kbp_pkg::TIME_W-1:0]   dividend_i,
  input  wire logic [kbp_pkg::INTV_W-1:0]   divisor_i,
  output logic                              done_o,
  output logic [kbp_pkg::TIME_W-1:0]        quot_o,
  output logic [kbp_pkg::INTV_W-1:0]        rem_o
);
  import kbp_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic [INTV_W-1:0] rem_q, rem_d;
  logic [INTV_W:0]   shifted;
  logic [INTV_W:0]   diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[TIME_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(TIME_W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      quo_d  = {quo_q[TIME_W-2:0], ge};
      rem_d  = ge ? diff[INTV_W-1:0] : shifted[INTV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### hw/rtl/kbp_dpath.sv
// datapath of the policer: request registers, bucket memory, refill arithmetic
// depends on kbp_pkg and kbp_div
`default_nettype none
module kbp_dpath #(
  parameter int unsigned BUCKET_COUNT = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire kbp_pkg::kbp_cmd_t            cmd_i,
  output kbp_pkg::kbp_sts_t                 sts_o,
  input  wire logic [kbp_pkg::IDX_W-1:0]    bucket_index_i,
  input  wire logic [kbp_pkg::TOK_W-1:0]    cost_i,
  input  wire logic [kbp_pkg::INTV_W-1:0]   interval_us_i,
  input  wire logic [kbp_pkg::TOK_W-1:0]    burst_size_i,
  input  wire logic [kbp_pkg::TIME_W-1:0]   now_us_i,
  output logic                              done_o,
  output logic                              accepted_o
);
  import kbp_pkg::*;

  localparam int unsigned AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic [IDX_W-1:0]  idx_q;
  logic [TOK_W-1:0]  cost_q;
  logic [INTV_W-1:0] intv_q;
  logic [TOK_W-1:0]  burst_q;
  logic [TIME_W-1:0] now_q;

  kbp_entry_t        mem [BUCKET_COUNT];
  kbp_entry_t        rd_q;
  kbp_entry_t        wd;
  logic              we;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     addr;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]     clr_q;

  logic              done_q;
  logic              acc_q, acc_d;

  logic              bad_cfg;
  logic              zero_cost;
  logic              out_of_range;
  logic              early_acc;

  logic              div_done;
  logic [TIME_W-1:0] quot;
  logic [INTV_W-1:0] rem;
  logic [TIME_W-1:0] elapsed;

  logic              earned_big;
  logic [TOK_W:0]    sum;
  logic [TOK_W-1:0]  avail;
  logic              upd_acc;
  logic [TOK_W-1:0]  upd_tok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q   <= bucket_index_i;
      cost_q  <= cost_i;
      intv_q  <= interval_us_i;
      burst_q <= burst_size_i;
      now_q   <= now_us_i;
    end
  end

  // early decisions
  assign bad_cfg      = (intv_q == '0) || (burst_q == '0);
  assign zero_cost    = (cost_q == '0);
  assign out_of_range = (32'(idx_q) >= BUCKET_COUNT);
  assign early_acc    = !bad_cfg && zero_cost;

  assign idx_ext = (AW+IDX_W)'(idx_q);
  assign addr    = idx_ext[AW-1:0];

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // refill
  assign elapsed    = now_q - rd_q.last_time;
  assign earned_big = (quot[TIME_W-1:TOK_W] != '0) || (quot[TOK_W-1:0] >= burst_q);
  assign sum        = {1'b0, quot[TOK_W-1:0]} + {1'b0, rd_q.tokens};
  assign avail      = (earned_big || (sum >= {1'b0, burst_q})) ? burst_q : sum[TOK_W-1:0];
  assign upd_acc    = (cost_q <= avail);
  assign upd_tok    = upd_acc ? (avail - cost_q) : avail;

  kbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (elapsed),
    .divisor_i  (intv_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // memory write port
  always_comb begin
    we = cmd_i.clr_step || cmd_i.wr_new || cmd_i.wr_upd;
    wa = cmd_i.clr_step ? clr_q : addr;
    wd = '0;
    if (cmd_i.wr_new) begin
      wd.valid     = 1'b1;
      wd.last_time = now_q;
      wd.tokens    = burst_q - cost_q;
    end else if (cmd_i.wr_upd) begin
      wd.valid     = 1'b1;
      wd.last_time = now_q - TIME_W'(rem);
      wd.tokens    = upd_tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // result beat
  always_comb begin
    acc_d = 1'b0;
    if (cmd_i.finish_early) begin
      acc_d = early_acc;
    end else if (cmd_i.wr_new) begin
      acc_d = 1'b1;
    end else if (cmd_i.wr_upd) begin
      acc_d = upd_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      acc_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish_early || cmd_i.wr_new || cmd_i.wr_upd;
      acc_q  <= acc_d;
    end
  end

  assign sts_o.clr_last    = (clr_q == AW'(BUCKET_COUNT - 1));
  assign sts_o.early_done  = bad_cfg || zero_cost || (cost_q > burst_q) || out_of_range;
  assign sts_o.entry_valid = rd_q.valid;
  assign sts_o.div_done    = div_done;

  assign done_o     = done_q;
  assign accepted_o = acc_q;

endmodule
`default_nettype wire

### hw/rtl/keyed_token_bucket_policer_core.sv
// top level of the keyed token bucket policer
// depends on kbp_pkg, kbp_ctrl, kbp_dpath and assert_macros.svh
`default_nettype none
// A request is taken when start is high while busy is low. Its verdict comes
// back as a one-cycle beat on done_o with accepted_o; the receiver cannot stall
// it, so it must sample done_o every cycle. Requests settled without the table
// (zero interval or burst, zero cost, cost above burst, index beyond the table)
// give their beat out of the check state, a first use of a bucket after the
// table read, and a refill of a used bucket after the 56-step restoring
// divider splits elapsed time into whole intervals. After reset busy stays
// high while the bucket memory is cleared one entry a cycle.
module keyed_token_bucket_policer_core #(
  parameter int unsigned BUCKET_COUNT = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [kbp_pkg::IDX_W-1:0]    bucket_index_i,
  input  wire logic [kbp_pkg::TOK_W-1:0]    cost_i,
  input  wire logic [kbp_pkg::INTV_W-1:0]   interval_us_i,
  input  wire logic [kbp_pkg::TOK_W-1:0]    burst_size_i,
  input  wire logic [kbp_pkg::TIME_W-1:0]   now_us_i,
  output logic                              done_o,
  output logic                              accepted_o
);
  import kbp_pkg::*;

  `include "assert_macros.svh"

  kbp_cmd_t cmd;
  kbp_sts_t sts;

  kbp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  kbp_dpath #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bucket_index_i (bucket_index_i),
    .cost_i         (cost_i),
    .interval_us_i  (interval_us_i),
    .burst_size_i   (burst_size_i),
    .now_us_i       (now_us_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o)
  );

  `ASSERT_NEXT(a_take_sets_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_NEXT(a_single_beat, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_IMPLIES(a_beat_when_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_IMPLIES(a_acc_only_in_beat, clk_i, rst_ni, accepted_o, done_o)

endmodule
`default_nettype wire

### bench/tb_keyed_token_bucket_policer_core.sv
// self-checking bench for keyed_token_bucket_policer_core: directed and random requests
// a local bucket table predicts each verdict beat; depends on kbp_pkg and the core rtl
`timescale 1ns / 1ps
module tb_keyed_token_bucket_policer_core;
  import kbp_pkg::*;

  localparam int unsigned BUCKET_COUNT = 1024;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam bit [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    bit [IDX_W-1:0]  idx;
    bit [TOK_W-1:0]  cost;
    bit [INTV_W-1:0] intv;
    bit [TOK_W-1:0]  burst;
    bit [TIME_W-1:0] now;
  } policer_req_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [IDX_W-1:0]  bucket_index_i;
  logic [TOK_W-1:0]  cost_i;
  logic [INTV_W-1:0] interval_us_i;
  logic [TOK_W-1:0]  burst_size_i;
  logic [TIME_W-1:0] now_us_i;
  logic              done_o;
  logic              accepted_o;

  bit              bkt_valid  [BUCKET_COUNT];
  bit [TIME_W-1:0] bkt_stamp  [BUCKET_COUNT];
  bit [TOK_W-1:0]  bkt_tokens [BUCKET_COUNT];
  bit              verdict_q[$];
  int unsigned     mismatch_count;
  bit              gaps_on;

  keyed_token_bucket_policer_core #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .bucket_index_i (bucket_index_i),
    .cost_i         (cost_i),
    .interval_us_i  (interval_us_i),
    .burst_size_i   (burst_size_i),
    .now_us_i       (now_us_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic policer_req_t mk_req(input int unsigned idx, input int unsigned cost,
                                          input bit [INTV_W-1:0] intv,
                                          input int unsigned burst,
                                          input bit [TIME_W-1:0] now);
    policer_req_t r;
    r.idx   = IDX_W'(idx);
    r.cost  = TOK_W'(cost);
    r.intv  = intv;
    r.burst = TOK_W'(burst);
    r.now   = now;
    return r;
  endfunction

  function automatic bit predict_verdict(input policer_req_t r);
    bit [TIME_W-1:0] elapsed;
    bit [TIME_W-1:0] earned;
    bit [63:0]       avail;
    bit              ok;
    ok = 1'b0;
    if (r.intv == 0 || r.burst == 0) return 1'b0;
    if (r.cost == 0) return 1'b1;
    if (r.cost > r.burst || r.idx >= BUCKET_COUNT) return 1'b0;
    if (bkt_valid[r.idx]) begin
      elapsed = r.now - bkt_stamp[r.idx];
      earned  = elapsed / r.intv;
      bkt_stamp[r.idx] = bkt_stamp[r.idx] + earned * r.intv;
      avail = 64'(earned) + 64'(bkt_tokens[r.idx]);
      if (avail > 64'(r.burst)) avail = 64'(r.burst);
    end else begin
      bkt_valid[r.idx] = 1'b1;
      bkt_stamp[r.idx] = r.now;
      avail = 64'(r.burst);
    end
    if (64'(r.cost) <= avail) begin
      avail = avail - 64'(r.cost);
      ok = 1'b1;
    end
    bkt_tokens[r.idx] = avail[TOK_W-1:0];
    return ok;
  endfunction

  task automatic report_mismatch(input string what, input logic exp_v, input logic act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s, expected accepted=%b actual=%b", $realtime, what,
               exp_v, act_v);
  endtask

  task automatic send_request(input policer_req_t r);
    start          <= 1'b1;
    bucket_index_i <= r.idx;
    cost_i         <= r.cost;
    interval_us_i  <= r.intv;
    burst_size_i   <= r.burst;
    now_us_i       <= r.now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    verdict_q.push_back(predict_verdict(r));
  endtask

  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // verdict beats cannot be held off, so every cycle is sampled
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (verdict_q.size() == 0) report_mismatch("beat with nothing pending", 1'bx, accepted_o);
      else if (verdict_q[0] !== accepted_o) report_mismatch("verdict", verdict_q.pop_front(),
                                                            accepted_o);
      else void'(verdict_q.pop_front());
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic reset_dut();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_reject_cases();
    send_request(mk_req(0, 1, 0, 10, 0));
    maybe_idle();
    send_request(mk_req(0, 1, 100, 0, 0));
    maybe_idle();
    send_request(mk_req(0, 65535, 1, 65534, 0));
    send_request(mk_req(0, 0, 0, 0, TIME_MAX));
  endtask

  task automatic test_zero_cost();
    send_request(mk_req(1023, 0, 32'hFFFF_FFFF, 65535, TIME_MAX));
    maybe_idle();
    send_request(mk_req(3, 0, 1, 1, 0));
  endtask

  task automatic test_first_use_and_refill();
    send_request(mk_req(5, 3, 100, 4, 1000));
    send_request(mk_req(5, 2, 100, 4, 1050));
    maybe_idle();
    send_request(mk_req(5, 2, 100, 4, 1250));
    send_request(mk_req(5, 4, 100, 4, 1250));
    send_request(mk_req(1023, 65535, 1, 65535, TIME_MAX));
  endtask

  task automatic test_time_wrap();
    send_request(mk_req(1023, 1, 1, 65535, 5));
    maybe_idle();
    send_request(mk_req(7, 1, 32'hFFFF_FFFF, 1, 0));
    send_request(mk_req(7, 1, 32'hFFFF_FFFF, 1, TIME_MAX));
    send_request(mk_req(8, 1, 1, 65535, TIME_MAX - 3));
    send_request(mk_req(8, 65535, 1, 65535, 56'd60000));
  endtask

  task automatic test_burst_shrink();
    send_request(mk_req(9, 1, 10, 100, 0));
    maybe_idle();
    send_request(mk_req(9, 5, 10, 5, 0));
    send_request(mk_req(9, 1, 10, 5, 9));
    send_request(mk_req(9, 2, 10, 100, 25));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    policer_req_t    r;
    int unsigned     hot_idx   [16];
    int unsigned     hot_intv  [16];
    int unsigned     hot_burst [16];
    bit [TIME_W-1:0] clock_now;
    int unsigned     n;
    int unsigned     k;
    int unsigned     sel;
    int unsigned     roll;
    for (n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        for (k = 0; k < 16; k++) begin
          hot_idx[k]   = $urandom_range(0, BUCKET_COUNT - 1);
          hot_intv[k]  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                                     : $urandom_range(1, 300);
          hot_burst[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 64);
        end
        if ($urandom_range(0, 3) == 0) clock_now = TIME_MAX - TIME_W'($urandom_range(0, 20000));
        else clock_now = TIME_W'({$urandom, $urandom});
      end
      sel  = $urandom_range(0, 15);
      roll = $urandom_range(0, 99);
      clock_now = clock_now + TIME_W'($urandom_range(0, 3)) * hot_intv[sel]
                  + TIME_W'($urandom_range(0, hot_intv[sel]));
      r = mk_req(hot_idx[sel], 1, hot_intv[sel], hot_burst[sel], clock_now);
      if (roll < 75) begin
        if ($urandom_range(0, 19) == 0) r.burst = TOK_W'($urandom_range(1, hot_burst[sel]));
        if ($urandom_range(0, 9) == 0) r.cost = r.burst;
        else r.cost = TOK_W'($urandom_range(1, (r.burst > 8) ? r.burst / 4 : r.burst));
      end else if (roll < 85) begin
        r = mk_req($urandom, $urandom, $urandom, $urandom, TIME_W'({$urandom, $urandom}));
      end else if (roll < 90) begin
        if ($urandom_range(0, 1) == 0) r.intv = '0;
        else r.burst = '0;
        r.cost = TOK_W'($urandom);
      end else if (roll < 95) begin
        r.burst = TOK_W'($urandom_range(0, 65534));
        r.cost  = TOK_W'($urandom_range(r.burst + 1, 65535));
      end else begin
        r.cost = '0;
        r.burst = TOK_W'($urandom);
        r.intv  = INTV_W'($urandom);
      end
      send_request(r);
      maybe_idle();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    bucket_index_i = '0;
    cost_i         = '0;
    interval_us_i  = '0;
    burst_size_i   = '0;
    now_us_i       = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    reset_dut();
    test_reject_cases();
    test_zero_cost();
    test_first_use_and_refill();
    test_time_wrap();
    test_burst_shrink();
    test_random_traffic(1200);
    gaps_on = 1'b0;
    test_random_traffic(300);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0) report_mismatch("verdict never arrived", verdict_q[0], 1'bx);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
